@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the STUN response parser.
// Each macro names its label, the clock, the active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

@@ rtl/core/sbrp_pkg.sv @@
// Package for the STUN binding response parser: item types, status codes, protocol constants.
// No dependencies; every other RTL file but assert_macros.svh imports it.
`timescale 1ns / 1ps

package sbrp_pkg;

	localparam logic [31:0] MAGIC_COOKIE   = 32'h2112A442;
	localparam logic [15:0] TYPE_BIND_RESP = 16'h0101;
	localparam logic [15:0] ATTR_MAPPED    = 16'h0001;
	localparam logic [15:0] ATTR_XOR       = 16'h0020;
	localparam logic [7:0]  FAMILY_IPV4    = 8'h01;
	localparam logic [16:0] HDR_BYTES      = 17'd20;
	localparam logic [16:0] POS_MAX        = 17'h1FFFF;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_SHORT      = 3'd1,
		ST_BAD_TYPE   = 3'd2,
		ST_BAD_COOKIE = 3'd3,
		ST_TRUNCATED  = 3'd4,
		ST_NO_ADDR    = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] mapped_port;
		logic [31:0] mapped_ip;
		logic        from_xor;
	} out_item_t;

endpackage

@@ rtl/core/sbrp_chan_if.sv @@
// Valid/ready channel interfaces for the message byte stream and the verdict stream.
// Depends on sbrp_pkg for the payload types.
`timescale 1ns / 1ps

interface sbrp_in_if import sbrp_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sbrp_out_if import sbrp_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/sbrp_parse.sv @@
// Message state registers and the per-byte header check and attribute scan.
// Depends on sbrp_pkg; produces the verdict for the byte currently presented.
`timescale 1ns / 1ps

module sbrp_parse import sbrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	output out_item_t result
);

	logic [16:0] pos_q, pos_d;
	logic [15:0] type_q, type_d;
	logic [15:0] len_q, len_d;
	logic [31:0] cookie_q, cookie_d;
	logic [16:0] next_q, next_d;
	logic [15:0] kind_q, kind_d;
	logic [15:0] size_q, size_d;
	logic [7:0]  family_q, family_d;
	logic [15:0] port_q, port_d;
	logic [31:0] ip_q, ip_d;
	logic        found_q, found_d;
	logic        stopped_q, stopped_d;

	logic [7:0]  b;
	logic [16:0] msg_end;
	logic [16:0] off;
	logic [16:0] padded;
	logic [17:0] nxt;
	logic        scan_go;
	logic        overrun;
	logic        hit;
	logic [17:0] count;

	always_comb begin
		b         = item.data_byte;
		type_d    = type_q;
		len_d     = len_q;
		cookie_d  = cookie_q;
		next_d    = next_q;
		kind_d    = kind_q;
		size_d    = size_q;
		family_d  = family_q;
		port_d    = port_q;
		ip_d      = ip_q;
		found_d   = found_q;
		stopped_d = stopped_q;

		msg_end = HDR_BYTES + {1'b0, len_q};
		scan_go = (pos_q >= HDR_BYTES) && (pos_q < msg_end) && !found_q && !stopped_q
			&& (pos_q >= next_q);
		off     = pos_q - next_q;

		// Size field update happens first so the overrun and step checks see the new value.
		if (scan_go && (off == 17'd2 || off == 17'd3)) begin
			size_d = {size_q[7:0], b};
		end
		padded  = ({1'b0, size_d} + 17'd3) & ~17'd3;
		nxt     = {1'b0, next_q} + 18'd4 + {1'b0, padded};
		overrun = (off == 17'd3)
			&& (({1'b0, next_q} + 18'd4 + {2'b00, size_d}) > {1'b0, msg_end});
		hit     = (off == 17'd11) && (kind_q == ATTR_MAPPED || kind_q == ATTR_XOR)
			&& (size_q >= 16'd8) && (family_q == FAMILY_IPV4);

		if (pos_q < 17'd2) begin
			type_d = {type_q[7:0], b};
		end else if (pos_q < 17'd4) begin
			len_d = {len_q[7:0], b};
		end else if (pos_q < 17'd8) begin
			cookie_d = {cookie_q[23:0], b};
		end else if (scan_go) begin
			if (off < 17'd2) begin
				kind_d = {kind_q[7:0], b};
			end else if (off == 17'd5) begin
				family_d = b;
			end else if (off == 17'd6 || off == 17'd7) begin
				port_d = {port_q[7:0], b};
			end else if (off >= 17'd8 && off <= 17'd11) begin
				ip_d = {ip_q[23:0], b};
			end

			if (overrun) begin
				stopped_d = 1'b1;
			end else if (hit) begin
				if (kind_q == ATTR_XOR) begin
					port_d = port_d ^ MAGIC_COOKIE[31:16];
					ip_d   = ip_d ^ MAGIC_COOKIE;
				end
				found_d = 1'b1;
			end else if ({1'b0, off} == {1'b0, padded} + 18'd3) begin
				next_d = (nxt > {1'b0, POS_MAX}) ? POS_MAX : nxt[16:0];
			end
		end

		pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + 17'd1;
		count = {1'b0, pos_q} + 18'd1;

		if (count < {1'b0, HDR_BYTES}) begin
			result.status = ST_SHORT;
		end else if (type_d != TYPE_BIND_RESP) begin
			result.status = ST_BAD_TYPE;
		end else if (cookie_d != MAGIC_COOKIE) begin
			result.status = ST_BAD_COOKIE;
		end else if (count < {1'b0, HDR_BYTES} + {2'b00, len_d}) begin
			result.status = ST_TRUNCATED;
		end else if (!found_d) begin
			result.status = ST_NO_ADDR;
		end else begin
			result.status = ST_OK;
		end

		if (result.status == ST_OK) begin
			result.mapped_port = port_d;
			result.mapped_ip   = ip_d;
			result.from_xor    = (kind_d == ATTR_XOR);
		end else begin
			result.mapped_port = '0;
			result.mapped_ip   = '0;
			result.from_xor    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			type_q    <= '0;
			len_q     <= '0;
			cookie_q  <= '0;
			next_q    <= HDR_BYTES;
			kind_q    <= '0;
			size_q    <= '0;
			family_q  <= '0;
			port_q    <= '0;
			ip_q      <= '0;
			found_q   <= 1'b0;
			stopped_q <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				// The verdict closes the message; start over for the next one.
				pos_q     <= '0;
				type_q    <= '0;
				len_q     <= '0;
				cookie_q  <= '0;
				next_q    <= HDR_BYTES;
				kind_q    <= '0;
				size_q    <= '0;
				family_q  <= '0;
				port_q    <= '0;
				ip_q      <= '0;
				found_q   <= 1'b0;
				stopped_q <= 1'b0;
			end else begin
				pos_q     <= pos_d;
				type_q    <= type_d;
				len_q     <= len_d;
				cookie_q  <= cookie_d;
				next_q    <= next_d;
				kind_q    <= kind_d;
				size_q    <= size_d;
				family_q  <= family_d;
				port_q    <= port_d;
				ip_q      <= ip_d;
				found_q   <= found_d;
				stopped_q <= stopped_d;
			end
		end
	end

endmodule

@@ rtl/core/sbrp_out_reg.sv @@
// Verdict output register driving the result channel.
// Depends on sbrp_pkg and sbrp_chan_if.
`timescale 1ns / 1ps

module sbrp_out_reg import sbrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  out_item_t         result,
	output logic              free,
	sbrp_out_if.source        verdict
);

	logic      valid_q;
	out_item_t data_q;

	// The slot can take a new verdict when empty or when the held one leaves this cycle.
	assign free = !valid_q || verdict.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= result;
		end
	end

	assign verdict.valid = valid_q;
	assign verdict.data  = data_q;

endmodule

@@ rtl/core/stun_binding_response_parser_top.sv @@
// STUN binding response parser. Takes one message byte per clock while input ready is high, with
// a mark on the final byte, and gives one verdict per message: status, and the mapped IPv4 port
// and address when the header checks pass and a MAPPED or XOR-MAPPED attribute was found. Each
// byte is captured in an input register and the header check, attribute scan and verdict are
// computed from it in the following cycle; the verdict is then loaded into the output register
// and offered from there. Input ready drops only while a final byte waits behind a verdict that
// the sink has not yet taken; the single output register sets that limit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stun_binding_response_parser_top import sbrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sbrp_in_if.sink    msg,
	sbrp_out_if.source verdict
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      adv;
	logic      out_free;
	out_item_t result;

	// A byte in the input register moves on unless it closes a message and the verdict slot is busy.
	assign adv       = valid_s1 && (!item_s1.last_byte || out_free);
	assign msg.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			item_s1 <= msg.data;
		end
	end

	sbrp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.result (result)
	);

	sbrp_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (adv && item_s1.last_byte),
		.result  (result),
		.free    (out_free),
		.verdict (verdict)
	);

	`ASSERT_NEXT(a_last_gives_verdict, clk, arst_n, adv && item_s1.last_byte, verdict.valid)
	`ASSERT_IMPL(a_fail_zero_fields, clk, arst_n, verdict.valid && verdict.data.status != ST_OK, verdict.data.mapped_port == 16'd0 && verdict.data.mapped_ip == 32'd0 && !verdict.data.from_xor)
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, !msg.ready, valid_s1 && item_s1.last_byte && verdict.valid && !verdict.ready)

endmodule

@@ bench/tb_stun_binding_response_parser_top.sv @@
// Self-checking bench for the STUN binding response parser: byte stream in, one verdict per message.
// Depends on sbrp_pkg, the sbrp_in_if and sbrp_out_if channels and stun_binding_response_parser_top.
`timescale 1ns / 1ps

module tb_stun_binding_response_parser_top;
	import sbrp_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 2_000_000;
	localparam int unsigned HOLD_OFF_CYCLES = 400;

	// Tracks the parse of the current message and keeps the verdicts still owed by the block.
	class verdict_board;
		logic [16:0] pos;
		logic [15:0] hdr_type;
		logic [15:0] msg_len;
		logic [31:0] cookie;
		logic [16:0] attr_start;
		logic [15:0] attr_kind;
		logic [15:0] attr_size;
		logic [7:0]  family;
		logic [15:0] port;
		logic [31:0] ip;
		bit          found;
		bit          stopped;
		out_item_t   expected_verdicts[$];
		int unsigned failures;
		int unsigned verdicts_checked;

		function new();
			failures = 0;
			verdicts_checked = 0;
			clear_state();
		endfunction

		function void clear_state();
			pos = '0;
			hdr_type = '0;
			msg_len = '0;
			cookie = '0;
			attr_start = HDR_BYTES;
			attr_kind = '0;
			attr_size = '0;
			family = '0;
			port = '0;
			ip = '0;
			found = 0;
			stopped = 0;
		endfunction

		function void scan_attr_byte(int unsigned p, logic [7:0] b);
			int unsigned stop_at, a, off, padded, nxt;
			stop_at = HDR_BYTES + msg_len;
			a = attr_start;
			if (p >= stop_at || found || stopped || p < a)
				return;
			off = p - a;
			if (off < 2)
				attr_kind = {attr_kind[7:0], b};
			else if (off < 4)
				attr_size = {attr_size[7:0], b};
			else if (off == 5)
				family = b;
			else if (off == 6 || off == 7)
				port = {port[7:0], b};
			else if (off >= 8 && off <= 11)
				ip = {ip[23:0], b};

			if (off == 3 && a + 4 + attr_size > stop_at) begin
				stopped = 1;
				return;
			end
			if (off == 11 && (attr_kind == ATTR_MAPPED || attr_kind == ATTR_XOR) &&
					attr_size >= 8 && family == FAMILY_IPV4) begin
				if (attr_kind == ATTR_XOR) begin
					port = port ^ MAGIC_COOKIE[31:16];
					ip = ip ^ MAGIC_COOKIE;
				end
				found = 1;
				return;
			end
			padded = (attr_size + 3) & ~32'd3;
			if (off >= 3 && off == 3 + padded) begin
				nxt = a + 4 + padded;
				attr_start = (nxt > POS_MAX) ? POS_MAX : nxt[16:0];
			end
		endfunction

		function void note_request(in_item_t req);
			int unsigned p, count;
			out_item_t v;
			p = pos;
			if (p < 2)
				hdr_type = {hdr_type[7:0], req.data_byte};
			else if (p < 4)
				msg_len = {msg_len[7:0], req.data_byte};
			else if (p < 8)
				cookie = {cookie[23:0], req.data_byte};
			else if (p >= HDR_BYTES)
				scan_attr_byte(p, req.data_byte);
			if (pos < POS_MAX)
				pos = pos + 1;
			if (!req.last_byte)
				return;

			count = p + 1;
			if (count < HDR_BYTES)
				v.status = ST_SHORT;
			else if (hdr_type != TYPE_BIND_RESP)
				v.status = ST_BAD_TYPE;
			else if (cookie != MAGIC_COOKIE)
				v.status = ST_BAD_COOKIE;
			else if (count < HDR_BYTES + msg_len)
				v.status = ST_TRUNCATED;
			else if (!found)
				v.status = ST_NO_ADDR;
			else
				v.status = ST_OK;
			v.mapped_port = (v.status == ST_OK) ? port : '0;
			v.mapped_ip = (v.status == ST_OK) ? ip : '0;
			v.from_xor = (v.status == ST_OK) && (attr_kind == ATTR_XOR);
			expected_verdicts.push_back(v);
			clear_state();
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_verdicts.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("ERROR: unexpected verdict status=%0d port=%h ip=%h xor=%0b",
						got.status, got.mapped_port, got.mapped_ip, got.from_xor);
				return;
			end
			want = expected_verdicts.pop_front();
			verdicts_checked++;
			if (got.status !== want.status || got.mapped_port !== want.mapped_port ||
					got.mapped_ip !== want.mapped_ip || got.from_xor !== want.from_xor) begin
				failures++;
				if (failures <= 10)
					$display("ERROR: verdict %0d expected %0d/%h/%h/%0b got %0d/%h/%h/%0b",
						verdicts_checked, want.status, want.mapped_port, want.mapped_ip,
						want.from_xor, got.status, got.mapped_port, got.mapped_ip,
						got.from_xor);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sbrp_in_if  msg_bus ();
	sbrp_out_if verdict_bus ();

	stun_binding_response_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg_bus),
		.verdict(verdict_bus)
	);

	verdict_board board = new();

	logic [7:0]  frame[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;
	int unsigned cycles = 0;
	int unsigned bytes_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned input_stalls = 0;

	always #10 clk = ~clk;

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			verdict_bus.ready <= 1'b0;
		end else begin
			verdict_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("stun_binding_response_parser_top regression: fail");
			$finish;
		end
		if (arst_n && verdict_bus.valid && verdict_bus.ready)
			board.check_result(verdict_bus.data);
		if (arst_n && msg_bus.valid && !msg_bus.ready)
			input_stalls++;
	end

	// Entered and left at a falling edge; valid stays high when the next byte follows at once.
	task automatic send_byte(logic [7:0] b, logic l);
		in_item_t req;
		while ($urandom_range(99) < send_idle_pct) begin
			msg_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req.data_byte = b;
		req.last_byte = l;
		msg_bus.valid <= 1'b1;
		msg_bus.data <= req;
		do
			@(posedge clk);
		while (!msg_bus.ready);
		board.note_request(req);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame.size(); i++)
			send_byte(frame[i], i == frame.size() - 1);
		frames_sent++;
	endtask

	task automatic put16(logic [15:0] v);
		frame.push_back(v[15:8]);
		frame.push_back(v[7:0]);
	endtask

	task automatic set_len(logic [15:0] len);
		frame[2] = len[15:8];
		frame[3] = len[7:0];
	endtask

	task automatic start_header(logic [15:0] mtype, logic [15:0] len, logic [31:0] ck);
		frame.delete();
		put16(mtype);
		put16(len);
		put16(ck[31:16]);
		put16(ck[15:0]);
		repeat (12) frame.push_back(8'($urandom));
	endtask

	// The value holds reserved, family, port and address, then random fill up to alen.
	task automatic put_attr(logic [15:0] kind, logic [15:0] alen, logic [7:0] fam,
			logic [15:0] aport, logic [31:0] aip);
		logic [7:0]  body[$];
		int unsigned padded;
		body = {8'($urandom), fam, aport[15:8], aport[7:0],
			aip[31:24], aip[23:16], aip[15:8], aip[7:0]};
		put16(kind);
		put16(alen);
		while (body.size() < alen)
			body.push_back(8'($urandom));
		padded = (alen + 3) & ~32'd3;
		for (int i = 0; i < padded; i++)
			frame.push_back(i < alen ? body[i] : 8'($urandom));
	endtask

	task automatic send_directed();
		frame.delete();
		frame.push_back(8'hFF);
		send_frame();
		frame.delete();
		repeat (19) frame.push_back(8'h00);
		send_frame();
		start_header(16'hFFFF, 16'h0000, MAGIC_COOKIE);
		send_frame();
		start_header(TYPE_BIND_RESP, 16'h0000, 32'hFFFFFFFF);
		send_frame();
		// Declared length not delivered.
		start_header(TYPE_BIND_RESP, 16'd12, MAGIC_COOKIE);
		send_frame();
		start_header(TYPE_BIND_RESP, 16'h0000, MAGIC_COOKIE);
		send_frame();
		start_header(TYPE_BIND_RESP, 16'd12, MAGIC_COOKIE);
		put_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'hFFFF, 32'hFFFFFFFF);
		send_frame();
		start_header(TYPE_BIND_RESP, 16'd12, MAGIC_COOKIE);
		put_attr(ATTR_XOR, 16'd8, FAMILY_IPV4, 16'h0000, 32'h00000000);
		send_frame();
		start_header(TYPE_BIND_RESP, 16'd12, MAGIC_COOKIE);
		put_attr(ATTR_XOR, 16'd8, FAMILY_IPV4, MAGIC_COOKIE[31:16], MAGIC_COOKIE);
		send_frame();
		// IPv6 is skipped, then a plain mapped address is taken.
		start_header(TYPE_BIND_RESP, 16'd36, MAGIC_COOKIE);
		put_attr(ATTR_XOR, 16'd20, 8'h02, 16'($urandom), $urandom);
		put_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
		send_frame();
		// A mapped attribute too short to hold an address is passed over.
		start_header(TYPE_BIND_RESP, 16'd20, MAGIC_COOKIE);
		put_attr(ATTR_MAPPED, 16'd4, FAMILY_IPV4, 16'($urandom), $urandom);
		put_attr(ATTR_XOR, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
		send_frame();
		start_header(TYPE_BIND_RESP, 16'd0, MAGIC_COOKIE);
		put_attr(16'h8022, 16'd5, 8'h00, 16'($urandom), $urandom);
		put_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
		set_len(16'(frame.size() - 20));
		send_frame();
		// The attribute claims more bytes than the message holds.
		start_header(TYPE_BIND_RESP, 16'd12, MAGIC_COOKIE);
		put_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
		frame[23] = 8'd40;
		send_frame();
		// Only the first usable address counts.
		start_header(TYPE_BIND_RESP, 16'd24, MAGIC_COOKIE);
		put_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
		put_attr(ATTR_XOR, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
		send_frame();
		// Address bytes past the declared end are not scanned.
		start_header(TYPE_BIND_RESP, 16'd0, MAGIC_COOKIE);
		put_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
		send_frame();
		start_header(TYPE_BIND_RESP, 16'd12, MAGIC_COOKIE);
		put_attr(ATTR_XOR, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
		repeat (7) frame.push_back(8'($urandom));
		send_frame();
		// Half an attribute header ends the message.
		start_header(TYPE_BIND_RESP, 16'd2, MAGIC_COOKIE);
		put16(ATTR_MAPPED);
		send_frame();
	endtask

	task automatic random_frame();
		int unsigned n, pick, true_len;
		logic [15:0] kind, alen;
		logic [7:0]  fam;
		logic [15:0] mtype;
		logic [31:0] ck;
		if ($urandom_range(99) < 10) begin
			frame.delete();
			n = $urandom_range(1, 30);
			repeat (n) frame.push_back(8'($urandom));
			send_frame();
			return;
		end
		mtype = ($urandom_range(99) < 8) ? 16'($urandom) : TYPE_BIND_RESP;
		ck = ($urandom_range(99) < 8) ? MAGIC_COOKIE ^ (32'd1 << $urandom_range(31))
			: MAGIC_COOKIE;
		start_header(mtype, 16'd0, ck);
		n = $urandom_range(0, 3);
		repeat (n) begin
			pick = $urandom_range(99);
			kind = (pick < 35) ? ATTR_MAPPED : (pick < 70) ? ATTR_XOR :
				(pick < 85) ? 16'h8022 : 16'($urandom);
			pick = $urandom_range(99);
			alen = (pick < 70) ? 16'd8 : (pick < 85) ? 16'd12 : 16'($urandom_range(0, 12));
			pick = $urandom_range(99);
			fam = (pick < 80) ? FAMILY_IPV4 : (pick < 90) ? 8'h02 : 8'($urandom);
			put_attr(kind, alen, fam, 16'($urandom), $urandom);
		end
		true_len = frame.size() - 20;
		set_len(16'(true_len));
		pick = $urandom_range(99);
		if (pick < 8)
			set_len(16'($urandom_range(0, true_len)));
		else if (pick < 16)
			set_len(16'(true_len + $urandom_range(1, 16)));
		else if (pick < 22)
			repeat ($urandom_range(1, 8)) void'(frame.pop_back());
		else if (pick < 28)
			repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
		send_frame();
	endtask

	task automatic run_random_phase(int unsigned s_pct, int unsigned r_pct);
		int unsigned first_byte, first_frame;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		first_byte = bytes_sent;
		first_frame = frames_sent;
		while (bytes_sent - first_byte < 300 || frames_sent - first_frame < 8)
			random_frame();
	endtask

	initial begin
		arst_n = 1'b0;
		msg_bus.valid = 1'b0;
		msg_bus.data = '0;
		verdict_bus.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 67;
		send_directed();
		hold_request = HOLD_OFF_CYCLES;
		run_random_phase(25, 67);
		run_random_phase(67, 25);
		// With the sender never idle, a long hold-off backs up into the input.
		hold_request = HOLD_OFF_CYCLES;
		run_random_phase(0, 0);
		msg_bus.valid <= 1'b0;

		while (board.expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d message bytes in %0d messages; %0d verdicts checked.",
			bytes_sent, frames_sent, board.verdicts_checked);
		$display("Input was held back on %0d cycles; %0d failures.",
			input_stalls, board.failures);
		if (board.failures == 0 && board.expected_verdicts.size() == 0)
			$display("stun_binding_response_parser_top regression: pass");
		else
			$display("stun_binding_response_parser_top regression: fail");
		$finish;
	end

endmodule
